@@ rtl/pulse_frequency_duty_meter_top_macros.svh @@
// Assertion helpers used by the checker
`ifndef PULSE_FREQUENCY_DUTY_METER_TOP_MACROS_SVH
`define PULSE_FREQUENCY_DUTY_METER_TOP_MACROS_SVH

// checked only out of reset
`define PFDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PFDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pfdm_pkg.sv @@
package pfdm_pkg;

  localparam int OUT_W   = 32;
  localparam int DUTY_W  = 7;
  localparam int CFG_DW  = 32;
  localparam int CFG_IW  = 1;

  localparam logic [OUT_W-1:0] TICK_RATE_RST = 32'd8000000;

  typedef logic [CFG_IW-1:0] cfg_idx_t;
  typedef logic [CFG_DW-1:0] cfg_data_t;

  localparam cfg_idx_t REG_TICK_RATE    = 1'b0;
  localparam cfg_idx_t REG_NOISE_CANCEL = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_RISE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [2:0] {
    SQ_RUN,
    SQ_PREP,
    SQ_FQ_GO,
    SQ_FQ_WAIT,
    SQ_DT_GO,
    SQ_DT_WAIT,
    SQ_OUT
  } seq_t;

endpackage

@@ rtl/pfdm_if.sv @@
interface pfdm_in_if;
  import pfdm_pkg::*;
  logic valid;
  logic ready;
  logic signal_level;
  logic start_req;
  modport source (output valid, signal_level, start_req, input ready);
  modport sink   (input valid, signal_level, start_req, output ready);
endinterface

interface pfdm_out_if;
  import pfdm_pkg::*;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  frequency_hz;
  logic [DUTY_W-1:0] duty_percent;
  logic [OUT_W-1:0]  high_ticks;
  logic [OUT_W-1:0]  low_ticks;
  logic              saturated;
  modport source (output valid, frequency_hz, duty_percent, high_ticks, low_ticks, saturated,
                  input ready);
  modport sink   (input valid, frequency_hz, duty_percent, high_ticks, low_ticks, saturated,
                  output ready);
endinterface

@@ rtl/pulse_frequency_duty_meter_top.sv @@
// Ordinary words: one per cycle, ready stays high.
// The closing rising edge word starts two DW-bit divides, DW = max(32, COUNT_WIDTH+7):
// frequency and duty go one after the other through one restoring divider that
// retires a quotient bit per cycle; input is held off meanwhile.
// The result sits in an output register; a stalled sink delays the return to ready.
// Synchronous active-low reset: idle, counts and filter cleared, registers to defaults.
module pulse_frequency_duty_meter_top #(
  parameter int COUNT_WIDTH    = 32,
  parameter int FILTER_SAMPLES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  pfdm_pkg::cfg_idx_t  cfg_idx,
  input  pfdm_pkg::cfg_data_t cfg_data,
  pfdm_in_if.sink             in_ch,
  pfdm_out_if.source          out_ch
);
  import pfdm_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int HW = FILTER_SAMPLES - 1;
  localparam int PW = CW + 1;
  localparam int DW = (CW + 7 > OUT_W) ? CW + 7 : OUT_W;
  localparam int XW = (CW > OUT_W) ? CW : OUT_W;

  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [CW-1:0] CNT_NEAR = CNT_MAX - CW'(1);
  localparam logic [XW-1:0] CLIP_MAX = XW'({OUT_W{1'b1}});

  // configuration
  logic [OUT_W-1:0] tick_rate_r;
  logic             noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RST;
      noise_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TICK_RATE:    tick_rate_r <= cfg_data[OUT_W-1:0];
        REG_NOISE_CANCEL: noise_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // measurement state
  phase_t        phase_r, phase_nxt;
  logic          qual_r, qual_nxt;
  logic [HW-1:0] hist_r, hist_nxt;
  logic [CW-1:0] high_r, high_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic          sat_r, sat_nxt;
  logic          trigger;
  logic          rise, fall;
  logic          acc;

  seq_t seq_r, seq_nxt;
  logic in_ready;
  logic div_start, div_done, out_load;
  logic [DW-1:0] div_dvd, div_q;

  logic [PW-1:0]    period_r;
  logic             period_zero_r;
  logic [DW-1:0]    prod_r;
  logic [OUT_W-1:0] freq_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_freq_r, out_high_r, out_low_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic             out_sat_r;
  logic [XW-1:0]    high_x, low_x;

  assign acc = in_ch.valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    qual_nxt  = qual_r;
    hist_nxt  = hist_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    sat_nxt   = sat_r;
    trigger   = 1'b0;
    rise      = 1'b0;
    fall      = 1'b0;
    if (acc) begin
      // qualifier runs on every word, in every phase
      if (!noise_r) begin
        qual_nxt = in_ch.signal_level;
      end else if (hist_r == (in_ch.signal_level ? {HW{1'b1}} : {HW{1'b0}})) begin
        qual_nxt = in_ch.signal_level;
      end
      hist_nxt = HW'({hist_r, in_ch.signal_level});
      rise     = !qual_r && qual_nxt;
      fall     = qual_r && !qual_nxt;
      if (in_ch.start_req) begin
        phase_nxt = PH_WAIT_RISE;
        high_nxt  = '0;
        low_nxt   = '0;
        sat_nxt   = 1'b0;
      end else begin
        case (phase_r)
          PH_WAIT_RISE: begin
            if (rise) begin
              phase_nxt = PH_HIGH;
              high_nxt  = '0;
              low_nxt   = '0;
            end
          end
          PH_HIGH: begin
            if (high_r == CNT_MAX) begin
              sat_nxt = 1'b1;
            end else begin
              high_nxt = high_r + CW'(1);
              if (high_r == CNT_NEAR) sat_nxt = 1'b1;
            end
            if (fall) begin
              phase_nxt = PH_LOW;
              low_nxt   = '0;
            end
          end
          PH_LOW: begin
            if (low_r == CNT_MAX) begin
              sat_nxt = 1'b1;
            end else begin
              low_nxt = low_r + CW'(1);
              if (low_r == CNT_NEAR) sat_nxt = 1'b1;
            end
            if (rise) begin
              phase_nxt = PH_IDLE;
              trigger   = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      qual_r  <= 1'b0;
      hist_r  <= '0;
      high_r  <= '0;
      low_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      qual_r  <= qual_nxt;
      hist_r  <= hist_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      sat_r   <= sat_nxt;
    end
  end

  // sequencer: next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SQ_RUN:     if (trigger) seq_nxt = SQ_PREP;
      SQ_PREP:    seq_nxt = SQ_FQ_GO;
      SQ_FQ_GO:   seq_nxt = SQ_FQ_WAIT;
      SQ_FQ_WAIT: if (div_done) seq_nxt = SQ_DT_GO;
      SQ_DT_GO:   seq_nxt = SQ_DT_WAIT;
      SQ_DT_WAIT: if (div_done) seq_nxt = SQ_OUT;
      SQ_OUT:     if (!out_valid_r || out_ch.ready) seq_nxt = SQ_RUN;
      default:    seq_nxt = SQ_RUN;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_dvd   = prod_r;
    out_load  = 1'b0;
    case (seq_r)
      SQ_RUN:   in_ready = 1'b1;
      SQ_FQ_GO: begin
        div_start = 1'b1;
        div_dvd   = DW'(tick_rate_r);
      end
      SQ_DT_GO: div_start = 1'b1;
      SQ_OUT:   out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) seq_r <= SQ_RUN;
    else        seq_r <= seq_nxt;
  end

  // operands; counts stay put while input is held off
  always_ff @(posedge clk) begin
    if (seq_r == SQ_PREP) begin
      period_r      <= PW'(high_r) + PW'(low_r);
      period_zero_r <= (high_r == '0) && (low_r == '0);
      prod_r        <= (DW'(high_r) << 6) + (DW'(high_r) << 5) + (DW'(high_r) << 2);
    end
    if (seq_r == SQ_FQ_WAIT && div_done) freq_r <= div_q[OUT_W-1:0];
  end

  pfdm_div #(
    .DW (DW),
    .PW (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign high_x = XW'(high_r);
  assign low_x  = XW'(low_r);

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (out_load)      out_valid_r <= 1'b1;
    else if (out_ch.ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_freq_r <= period_zero_r ? '0 : freq_r;
      out_duty_r <= period_zero_r ? '0 : div_q[DUTY_W-1:0];
      out_high_r <= (high_x > CLIP_MAX) ? {OUT_W{1'b1}} : high_x[OUT_W-1:0];
      out_low_r  <= (low_x > CLIP_MAX) ? {OUT_W{1'b1}} : low_x[OUT_W-1:0];
      out_sat_r  <= sat_r;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frequency_hz = out_freq_r;
  assign out_ch.duty_percent = out_duty_r;
  assign out_ch.high_ticks   = out_high_r;
  assign out_ch.low_ticks    = out_low_r;
  assign out_ch.saturated    = out_sat_r;

endmodule

@@ rtl/pfdm_div.sv @@
module pfdm_div #(
  parameter int DW = 55,
  parameter int PW = 49
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [PW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import pfdm_pkg::*;

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW-1:0]   q_r, q_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [PW-1:0]   dsr_r, dsr_nxt;

  logic [PW:0] shifted;
  logic [PW:0] diff;
  logic        ge;

  // restoring step: one quotient bit a cycle, MSB first
  assign shifted = {rem_r, q_r[DW-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start && !busy_r) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNTW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? diff[PW-1:0] : shifted[PW-1:0];
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/pfdm_checker.sv @@
`include "pulse_frequency_duty_meter_top_macros.svh"

module pfdm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pfdm_pkg::DUTY_W-1:0] duty_percent,
  input logic [pfdm_pkg::OUT_W-1:0]  high_ticks,
  input logic [pfdm_pkg::OUT_W-1:0]  low_ticks
);
  import pfdm_pkg::*;

  // a stalled word is held until taken
  `PFDM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out word dropped while stalled")

  // a word only appears after the divide, with input held off
  `PFDM_ASSERT(a_rise_after_busy, $rose(out_valid) |-> !$past(in_ready), "result without divide")

  // both phases count at least one tick, duty never above full scale
  `PFDM_ASSERT(a_out_sane, out_valid |-> (high_ticks != '0) && (low_ticks != '0) && (duty_percent <= 7'd100), "result fields out of range")

  // synchronous reset empties the output register
  `PFDM_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "out valid survived reset")

endmodule

bind pulse_frequency_duty_meter_top pfdm_checker u_pfdm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .duty_percent (out_ch.duty_percent),
  .high_ticks   (out_ch.high_ticks),
  .low_ticks    (out_ch.low_ticks)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pfdm_pkg::*;

  localparam int          HIST_W        = 3;   // previous raw samples kept by the qualifier
  localparam logic [63:0] COUNT_TOP     = 64'hFFFF_FFFF;
  localparam int          SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [OUT_W-1:0]  freq;
    logic [DUTY_W-1:0] duty;
    logic [OUT_W-1:0]  high_n;
    logic [OUT_W-1:0]  low_n;
    logic              sat;
  } meas_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;

  pfdm_in_if  in_ch ();
  pfdm_out_if out_ch ();

  pulse_frequency_duty_meter_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  // meter model state
  phase_t            m_phase;
  logic              m_qlvl;
  logic [HIST_W-1:0] m_hist;
  logic [63:0]       m_high;
  logic [63:0]       m_low;
  logic              m_sat;
  logic [OUT_W-1:0]  m_rate;
  logic              m_nc;

  meas_t pending_meas[$];
  int    mismatches   = 0;
  int    words_sent   = 0;
  int    in_idle_pct  = 0;
  int    out_stall_pct = 0;

  function automatic void meter_clear();
    m_phase = PH_IDLE;
    m_qlvl  = 1'b0;
    m_hist  = '0;
    m_high  = '0;
    m_low   = '0;
    m_sat   = 1'b0;
    m_rate  = TICK_RATE_RST;
    m_nc    = 1'b0;
  endfunction

  function automatic logic [63:0] count_inc(input logic [63:0] c);
    logic [63:0] n;
    if (c >= COUNT_TOP) begin
      n     = COUNT_TOP;
      m_sat = 1'b1;
    end else begin
      n = c + 64'd1;
      if (n == COUNT_TOP) m_sat = 1'b1;
    end
    return n;
  endfunction

  function automatic logic [31:0] clip_field(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic void meter_step(input logic lvl, input logic st,
                                     output meas_t res, output logic fired);
    logic        prev, nxt, rise, fall;
    logic [63:0] period, freq, duty;
    fired = 1'b0;
    res   = '0;
    prev  = m_qlvl;
    nxt   = prev;
    if (m_nc) begin
      if (m_hist == (lvl ? {HIST_W{1'b1}} : {HIST_W{1'b0}})) nxt = lvl;
    end else begin
      nxt = lvl;
    end
    m_hist = {m_hist[HIST_W-2:0], lvl};
    m_qlvl = nxt;
    rise   = !prev && nxt;
    fall   = prev && !nxt;

    // arming word: edge on the same tick is not taken
    if (st) begin
      m_phase = PH_WAIT_RISE;
      m_high  = '0;
      m_low   = '0;
      m_sat   = 1'b0;
      return;
    end

    case (m_phase)
      PH_WAIT_RISE: begin
        if (rise) begin
          m_phase = PH_HIGH;
          m_high  = '0;
          m_low   = '0;
        end
      end
      PH_HIGH: begin
        m_high = count_inc(m_high);
        if (fall) begin
          m_phase = PH_LOW;
          m_low   = '0;
        end
      end
      PH_LOW: begin
        m_low = count_inc(m_low);
        if (rise) begin
          period = m_high + m_low;
          freq   = '0;
          duty   = '0;
          if (period != 0) begin
            freq = {32'd0, m_rate} / period;
            duty = (m_high * 64'd100) / period;
          end
          res.freq   = freq[OUT_W-1:0];
          res.duty   = duty[DUTY_W-1:0];
          res.high_n = clip_field(m_high);
          res.low_n  = clip_field(m_low);
          res.sat    = m_sat;
          fired      = 1'b1;
          m_phase    = PH_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // prediction and checking, sampled at the edge
  always @(posedge clk) begin
    meas_t got, want;
    logic  fired;
    if (!rst_n) begin
      meter_clear();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TICK_RATE:    m_rate = cfg_data[OUT_W-1:0];
          REG_NOISE_CANCEL: m_nc   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        meter_step(in_ch.signal_level, in_ch.start_req, want, fired);
        if (fired) pending_meas.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.frequency_hz, out_ch.duty_percent, out_ch.high_ticks,
                out_ch.low_ticks, out_ch.saturated};
        if (pending_meas.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = pending_meas.pop_front();
          check_field("frequency_hz", want.freq, got.freq);
          check_field("duty_percent", want.duty, got.duty);
          check_field("high_ticks", want.high_n, got.high_n);
          check_field("low_ticks", want.low_n, got.low_n);
          check_field("saturated", want.sat, got.sat);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_word(input logic lvl, input logic st);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.signal_level <= lvl;
    in_ch.start_req    <= st;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // level held for n words, each flipped with probability glitch_pct
  task automatic send_run(input logic lvl, input int n, input int glitch_pct);
    repeat (n) send_word(($urandom_range(99) < glitch_pct) ? !lvl : lvl, 1'b0);
  endtask

  task automatic measure(input int hi_n, input int lo_n);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    send_run(1'b1, hi_n, 0);
    send_run(1'b0, lo_n, 0);
    send_word(1'b1, 1'b0);
  endtask

  // a wait on the clock first, so the last accepted word is already in the queue
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] rate, input logic nc);
    wait_drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_TICK_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_idx  <= REG_NOISE_CANCEL;
    cfg_data <= {31'd0, nc};
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic int run_len();
    if ($urandom_range(29) == 0) return $urandom_range(13, 150);
    return $urandom_range(1, 8);
  endfunction

  task automatic random_words(input int n_words);
    int target;
    int glitch;
    target = words_sent + n_words;
    glitch = m_nc ? 6 : 2;
    while (words_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_word(1'($urandom_range(1)), 1'b1);
        send_run(1'b0, $urandom_range(0, 3) + (m_nc ? 4 : 0), 0);
        send_run(1'b1, run_len(), glitch);
        send_run(1'b0, run_len(), glitch);
        send_run(1'b1, $urandom_range(1, m_nc ? 5 : 2), 0);
      end else begin
        repeat ($urandom_range(1, 10))
          send_word(1'($urandom_range(1)), $urandom_range(99) < 8);
      end
    end
  endtask

  task automatic test_basic_periods();
    measure(1, 1);    // shortest period, duty 50
    measure(5, 1);    // high duty
    measure(1, 6);
  endtask

  task automatic test_arming_cases();
    // level already high when armed: waits for the next rising edge
    send_word(1'b1, 1'b1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    // re-arm in the middle of a measurement
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
  endtask

  task automatic test_rate_extremes();
    set_config(32'hFFFF_FFFF, 1'b0);
    measure(1, 1);
    set_config(32'd1, 1'b0);
    measure(2, 3);    // frequency truncates to zero
    set_config(32'd0, 1'b0);
    measure(1, 2);
  endtask

  task automatic test_noise_filter();
    set_config(TICK_RATE_RST, 1'b1);
    send_word(1'b0, 1'b1);
    send_run(1'b0, 3, 0);
    send_run(1'b1, 2, 0);    // short glitch, ignored
    send_run(1'b0, 3, 0);
    send_run(1'b1, 4, 0);    // qualifies on the fourth sample
    send_word(1'b0, 1'b0);
    send_run(1'b1, 3, 0);
    send_run(1'b0, 4, 0);
    send_run(1'b1, 4, 0);
  endtask

  task automatic test_random_free_flow();
    set_config($urandom(), 1'b0);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    random_words(130);
  endtask

  task automatic test_random_sender_gaps();
    set_config($urandom(), 1'b1);
    in_idle_pct   = 83;
    out_stall_pct = 0;
    random_words(130);
  endtask

  task automatic test_random_sink_stalls();
    set_config(32'hFFFF_FFFF, 1'b0);
    in_idle_pct   = 0;
    out_stall_pct = 83;
    random_words(130);
  endtask

  task automatic test_random_mixed();
    set_config($urandom_range(1, 1000), 1'b1);
    in_idle_pct   = 30;
    out_stall_pct = 30;
    random_words(60);
    wait_drain();    // sender holds off until all results are back
    set_config($urandom(), 1'b0);
    random_words(60);
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= REG_TICK_RATE;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.signal_level <= 1'b0;
    in_ch.start_req    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_periods();
    test_arming_cases();
    test_rate_extremes();
    test_noise_filter();
    test_random_free_flow();
    test_random_sender_gaps();
    test_random_sink_stalls();
    test_random_mixed();

    in_idle_pct   = 0;
    out_stall_pct = 0;
    wait_drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pfdm_pkg.sv
rtl/pfdm_if.sv
rtl/pfdm_div.sv
rtl/pulse_frequency_duty_meter_top.sv
rtl/pfdm_checker.sv
test/tb_top.sv
